@@ src/lct_pkg.sv @@
package lct_pkg;

    // Default sizes of the directory.
    localparam int DEF_ENTRIES     = 16;
    localparam int DEF_KEY_BITS    = 48;
    localparam int DEF_LENGTH_BITS = 25;

    // Field widths on the ports.
    localparam int KIND_W   = 2;
    localparam int KEY_W    = 48;
    localparam int LEN_W    = 25;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 4;
    localparam int COUNT_W  = 5;
    localparam int CFG_W    = 5;

    // Packed stream widths, rounded up to whole bytes.
    localparam int IN_DATA_W  = 128;
    localparam int OUT_DATA_W = 64;

    // Capacity after reset.
    localparam logic [CFG_W-1:0] CAPACITY_RESET = 5'd16;

    // Request kinds.
    localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd0;
    localparam logic [KIND_W-1:0] KIND_READ   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd2;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd3;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STAT_MISS    = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_HIT     = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_OOR     = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_STORED  = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_UPDATED = 3'd4;
    localparam logic [STATUS_W-1:0] STAT_EVICT   = 3'd5;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_MATCH,
        S_EXEC,
        S_VFIND,
        S_VEMIT,
        S_STORE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic                capture;
        logic                match;
        logic                clear_all;
        logic                promote;
        logic                write_len;
        logic                vfind;
        logic                evict;
        logic                store;
        logic                emit;
        logic [STATUS_W-1:0] emit_status;
        logic                emit_last;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              hit;
        logic              out_of_range;
        logic              need_evict;
        logic              victim_found;
        logic              out_free;
    } t_stat;

endpackage

@@ src/lct_ctrl.sv @@
module lct_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  lct_pkg::t_stat i_stat,
    output logic           o_in_ready,
    output lct_pkg::t_cmd  o_cmd
);

    lct_pkg::t_state r_state;
    lct_pkg::t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lct_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            lct_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = lct_pkg::S_MATCH;
                end
            end
            lct_pkg::S_MATCH: begin
                n_state = lct_pkg::S_EXEC;
            end
            lct_pkg::S_EXEC: begin
                if (i_stat.kind == lct_pkg::KIND_INSERT && !i_stat.hit) begin
                    n_state = lct_pkg::S_VFIND;
                end else if (i_stat.out_free) begin
                    n_state = lct_pkg::S_IDLE;
                end
            end
            lct_pkg::S_VFIND: begin
                n_state = lct_pkg::S_VEMIT;
            end
            lct_pkg::S_VEMIT: begin
                if (!(i_stat.need_evict && i_stat.victim_found)) begin
                    n_state = lct_pkg::S_STORE;
                end else if (i_stat.out_free) begin
                    n_state = lct_pkg::S_VFIND;
                end
            end
            lct_pkg::S_STORE: begin
                if (i_stat.out_free) begin
                    n_state = lct_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = lct_pkg::S_IDLE;
            end
        endcase
    end

    // Commands for the current state.
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            lct_pkg::S_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.capture = 1'b1;
            end
            lct_pkg::S_MATCH: begin
                o_cmd.match = 1'b1;
            end
            lct_pkg::S_EXEC: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_last = 1'b1;
                    case (i_stat.kind)
                        lct_pkg::KIND_CLEAR: begin
                            o_cmd.clear_all   = 1'b1;
                            o_cmd.emit        = 1'b1;
                            o_cmd.emit_status = lct_pkg::STAT_MISS;
                        end
                        lct_pkg::KIND_INSERT: begin
                            if (i_stat.hit) begin
                                o_cmd.write_len   = 1'b1;
                                o_cmd.promote     = 1'b1;
                                o_cmd.emit        = 1'b1;
                                o_cmd.emit_status = lct_pkg::STAT_UPDATED;
                            end
                        end
                        default: begin
                            o_cmd.emit = 1'b1;
                            if (!i_stat.hit) begin
                                o_cmd.emit_status = lct_pkg::STAT_MISS;
                            end else if (i_stat.kind == lct_pkg::KIND_READ &&
                                         i_stat.out_of_range) begin
                                o_cmd.emit_status = lct_pkg::STAT_OOR;
                            end else begin
                                o_cmd.promote     = 1'b1;
                                o_cmd.emit_status = lct_pkg::STAT_HIT;
                            end
                        end
                    endcase
                end
            end
            lct_pkg::S_VFIND: begin
                o_cmd.vfind = 1'b1;
            end
            lct_pkg::S_VEMIT: begin
                if (i_stat.need_evict && i_stat.victim_found && i_stat.out_free) begin
                    o_cmd.evict       = 1'b1;
                    o_cmd.emit        = 1'b1;
                    o_cmd.emit_status = lct_pkg::STAT_EVICT;
                end
            end
            lct_pkg::S_STORE: begin
                if (i_stat.out_free) begin
                    o_cmd.store       = 1'b1;
                    o_cmd.emit        = 1'b1;
                    o_cmd.emit_status = lct_pkg::STAT_STORED;
                    o_cmd.emit_last   = 1'b1;
                end
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

@@ src/lct_datapath.sv @@
module lct_datapath #(
    parameter int ENTRIES     = lct_pkg::DEF_ENTRIES,
    parameter int KEY_BITS    = lct_pkg::DEF_KEY_BITS,
    parameter int LENGTH_BITS = lct_pkg::DEF_LENGTH_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    input  logic [lct_pkg::KIND_W-1:0]       i_kind,
    input  logic [KEY_BITS-1:0]              i_chunk_key,
    input  logic [LENGTH_BITS-1:0]           i_start_byte,
    input  logic [LENGTH_BITS-1:0]           i_byte_count,
    input  logic [LENGTH_BITS-1:0]           i_chunk_length,
    input  logic                             i_cfg_we,
    input  logic [lct_pkg::CFG_W-1:0]        i_cfg_wdata,
    input  lct_pkg::t_cmd                    i_cmd,
    output lct_pkg::t_stat                   o_stat,
    input  logic                             i_out_ready,
    output logic                             o_out_valid,
    output logic [lct_pkg::STATUS_W-1:0]     o_status,
    output logic [$clog2(ENTRIES)-1:0]       o_slot,
    output logic [KEY_BITS-1:0]              o_evicted_key,
    output logic [$clog2(ENTRIES+1)-1:0]     o_entry_count,
    output logic                             o_last
);

    localparam int IW   = $clog2(ENTRIES);
    localparam int CW   = $clog2(ENTRIES + 1);
    localparam int LW1  = LENGTH_BITS + 1;
    localparam int CMPW = (CW > lct_pkg::CFG_W) ? CW + 1 : lct_pkg::CFG_W + 1;

    // Capacity register.
    logic [lct_pkg::CFG_W-1:0] r_capacity;

    // Captured request.
    logic [lct_pkg::KIND_W-1:0] r_kind;
    logic [KEY_BITS-1:0]        r_key;
    logic [LENGTH_BITS-1:0]     r_len;
    logic [LW1-1:0]             r_sum;

    // Directory lanes.
    logic [ENTRIES-1:0]     r_valid;
    logic [IW-1:0]          r_rank     [ENTRIES];
    logic [KEY_BITS-1:0]    r_lane_key [ENTRIES];
    logic [LENGTH_BITS-1:0] r_lane_len [ENTRIES];
    logic [CW-1:0]          r_count;

    // Match and victim results.
    logic                   r_hit;
    logic [IW-1:0]          r_hit_idx;
    logic [IW-1:0]          r_hit_rank;
    logic [LENGTH_BITS-1:0] r_hit_len;
    logic                   r_need;
    logic                   r_vic_found;
    logic [IW-1:0]          r_vic_idx;
    logic [KEY_BITS-1:0]    r_vic_key;

    // Output register.
    logic                          r_out_valid;
    logic [lct_pkg::STATUS_W-1:0]  r_out_status;
    logic [IW-1:0]                 r_out_slot;
    logic [KEY_BITS-1:0]           r_out_key;
    logic [CW-1:0]                 r_out_count;
    logic                          r_out_last;

    logic                   c_hit;
    logic [IW-1:0]          c_hit_idx;
    logic                   c_vic_found;
    logic [IW-1:0]          c_vic_idx;
    logic [IW-1:0]          c_free_idx;
    logic [IW-1:0]          c_vic_rank;
    logic [CMPW-1:0]        c_cap;
    logic                   c_need;
    logic                   c_out_free;
    logic [CW-1:0]          c_count_after;
    logic [IW-1:0]          c_slot;

    // Key compare across all lanes; the lowest matching slot wins.
    always_comb begin
        c_hit     = 1'b0;
        c_hit_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (r_valid[i] && r_lane_key[i] == r_key) begin
                c_hit     = 1'b1;
                c_hit_idx = IW'(i);
            end
        end
    end

    // Least recent entry holds rank count-1; the highest such slot wins.
    assign c_vic_rank = IW'(r_count - CW'(1));
    always_comb begin
        c_vic_found = 1'b0;
        c_vic_idx   = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (r_valid[i] && r_rank[i] == c_vic_rank) begin
                c_vic_found = 1'b1;
                c_vic_idx   = IW'(i);
            end
        end
    end

    // Lowest free slot, slot zero when the directory is full.
    always_comb begin
        c_free_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                c_free_idx = IW'(i);
            end
        end
    end

    // Effective capacity is clamped to one through the number of lanes.
    always_comb begin
        if (r_capacity == '0) begin
            c_cap = CMPW'(1);
        end else if (CMPW'(r_capacity) > CMPW'(ENTRIES)) begin
            c_cap = CMPW'(ENTRIES);
        end else begin
            c_cap = CMPW'(r_capacity);
        end
    end
    assign c_need = (CMPW'(r_count) >= c_cap) && (r_count != '0);

    assign c_out_free = !r_out_valid || i_out_ready;

    // Status back to the controller.
    always_comb begin
        o_stat              = '0;
        o_stat.kind         = r_kind;
        o_stat.hit          = r_hit;
        o_stat.out_of_range = r_sum > LW1'(r_hit_len);
        o_stat.need_evict   = r_need;
        o_stat.victim_found = r_vic_found;
        o_stat.out_free     = c_out_free;
    end

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= lct_pkg::CAPACITY_RESET;
        end else if (i_cfg_we) begin
            r_capacity <= i_cfg_wdata;
        end
    end

    // Request capture, match and victim registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture && i_in_valid) begin
            r_kind <= i_kind;
            r_key  <= i_chunk_key;
            r_len  <= i_chunk_length;
            r_sum  <= LW1'(i_start_byte) + LW1'(i_byte_count);
        end
        if (i_cmd.match) begin
            r_hit      <= c_hit;
            r_hit_idx  <= c_hit_idx;
            r_hit_rank <= r_rank[c_hit_idx];
            r_hit_len  <= r_lane_len[c_hit_idx];
        end
        if (i_cmd.vfind) begin
            r_need      <= c_need;
            r_vic_found <= c_vic_found;
            r_vic_idx   <= c_vic_idx;
            r_vic_key   <= r_lane_key[c_vic_idx];
        end
    end

    // Valid bits, recency ranks and entry count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_count <= '0;
            for (int i = 0; i < ENTRIES; i++) begin
                r_rank[i] <= '0;
            end
        end else if (i_cmd.clear_all) begin
            r_valid <= '0;
            r_count <= '0;
            for (int i = 0; i < ENTRIES; i++) begin
                r_rank[i] <= '0;
            end
        end else if (i_cmd.promote) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (r_valid[i] && r_rank[i] < r_hit_rank) begin
                    r_rank[i] <= r_rank[i] + IW'(1);
                end
            end
            r_rank[r_hit_idx] <= '0;
        end else if (i_cmd.evict) begin
            r_valid[r_vic_idx] <= 1'b0;
            r_rank[r_vic_idx]  <= '0;
            r_count            <= r_count - CW'(1);
        end else if (i_cmd.store) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (r_valid[i]) begin
                    r_rank[i] <= r_rank[i] + IW'(1);
                end
            end
            r_valid[c_free_idx] <= 1'b1;
            r_rank[c_free_idx]  <= '0;
            r_count             <= r_count + CW'(1);
        end
    end

    // Stored keys and lengths.
    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            r_lane_key[c_free_idx] <= r_key;
            r_lane_len[c_free_idx] <= r_len;
        end else if (i_cmd.write_len) begin
            r_lane_len[r_hit_idx] <= r_len;
        end
    end

    // Slot and entry count reported with the result.
    always_comb begin
        case (i_cmd.emit_status)
            lct_pkg::STAT_HIT,
            lct_pkg::STAT_OOR,
            lct_pkg::STAT_UPDATED: c_slot = r_hit_idx;
            lct_pkg::STAT_EVICT:   c_slot = r_vic_idx;
            lct_pkg::STAT_STORED:  c_slot = c_free_idx;
            default:               c_slot = '0;
        endcase
        if (i_cmd.clear_all) begin
            c_count_after = '0;
        end else if (i_cmd.evict) begin
            c_count_after = r_count - CW'(1);
        end else if (i_cmd.store) begin
            c_count_after = r_count + CW'(1);
        end else begin
            c_count_after = r_count;
        end
    end

    // Result register toward the receiver.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_status <= i_cmd.emit_status;
            r_out_slot   <= c_slot;
            r_out_key    <= (i_cmd.emit_status == lct_pkg::STAT_EVICT) ? r_vic_key : '0;
            r_out_count  <= c_count_after;
            r_out_last   <= i_cmd.emit_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_slot        = r_out_slot;
    assign o_evicted_key = r_out_key;
    assign o_entry_count = r_out_count;
    assign o_last        = r_out_last;

endmodule

@@ src/lru_chunk_tag_cache.sv @@
// Fully associative directory of chunk tags kept in strict least-recently-used
// order. Chunk data lives elsewhere and is addressed by the reported slot.
// Requests arrive on the slave stream: tuser carries the kind (lookup, bounded
// read check, insert or update, clear all) and tdata carries key, start, count
// and length. Results leave on the master stream with the status in tuser and
// slot, evicted key and entry count in tdata; tlast marks the final result of
// a request. An insert of a new key first gives one eviction notice per entry
// removed, then the stored-new result.
// A lookup, read check, update or clear passes the capture, tag compare and execute
// states before its result is registered; a new insert then takes one victim search
// and eviction step per eviction, then a last search, before its stored-new result.
// A new request is taken once the previous one has issued its last result, so
// requests do not overlap; each passes through the capture, tag compare, victim
// search and rank update steps of the controller as its kind needs.
// The result register lets a request be taken while the last result waits; if
// the receiver stalls, the next result holds the controller until it drains.
// The capacity register is to be written with i_cfg_we only while the block is
// idle; the user must keep to this, as the block itself does not enforce it.
// After reset the directory is empty and the capacity is sixteen.
module lru_chunk_tag_cache #(
    parameter int ENTRIES     = lct_pkg::DEF_ENTRIES,
    parameter int KEY_BITS    = lct_pkg::DEF_KEY_BITS,
    parameter int LENGTH_BITS = lct_pkg::DEF_LENGTH_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // chunk_key[47:0], start_byte[72:48], byte_count[97:73], chunk_length[122:98]
    input  logic [((KEY_BITS + 3 * LENGTH_BITS + 7) / 8) * 8 - 1:0] i_s_axis_tdata,
    // kind[1:0]
    input  logic [lct_pkg::KIND_W-1:0]         i_s_axis_tuser,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // slot[3:0], evicted_key[51:4], entry_count[56:52]
    output logic [(($clog2(ENTRIES) + KEY_BITS + $clog2(ENTRIES + 1) + 7) / 8) * 8 - 1:0]
                                               o_m_axis_tdata,
    // status[2:0]
    output logic [lct_pkg::STATUS_W-1:0]       o_m_axis_tuser,
    output logic                               o_m_axis_tlast,
    input  logic                               i_cfg_we,
    input  logic [lct_pkg::CFG_W-1:0]          i_cfg_wdata
);

    localparam int SLOT_BITS  = $clog2(ENTRIES);
    localparam int COUNT_BITS = $clog2(ENTRIES + 1);
    localparam int OUT_W      = ((SLOT_BITS + KEY_BITS + COUNT_BITS + 7) / 8) * 8;

    lct_pkg::t_cmd  w_cmd;
    lct_pkg::t_stat w_stat;

    logic [SLOT_BITS-1:0]  w_slot;
    logic [KEY_BITS-1:0]   w_evicted_key;
    logic [COUNT_BITS-1:0] w_entry_count;

    lct_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_stat     (w_stat),
        .o_in_ready (o_s_axis_tready),
        .o_cmd      (w_cmd)
    );

    lct_datapath #(
        .ENTRIES     (ENTRIES),
        .KEY_BITS    (KEY_BITS),
        .LENGTH_BITS (LENGTH_BITS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_s_axis_tvalid),
        .i_kind         (i_s_axis_tuser),
        .i_chunk_key    (i_s_axis_tdata[KEY_BITS-1:0]),
        .i_start_byte   (i_s_axis_tdata[KEY_BITS +: LENGTH_BITS]),
        .i_byte_count   (i_s_axis_tdata[KEY_BITS + LENGTH_BITS +: LENGTH_BITS]),
        .i_chunk_length (i_s_axis_tdata[KEY_BITS + 2 * LENGTH_BITS +: LENGTH_BITS]),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_out_ready    (i_m_axis_tready),
        .o_out_valid    (o_m_axis_tvalid),
        .o_status       (o_m_axis_tuser),
        .o_slot         (w_slot),
        .o_evicted_key  (w_evicted_key),
        .o_entry_count  (w_entry_count),
        .o_last         (o_m_axis_tlast)
    );

    // Pack result fields, lowest field first, zero fill to the byte.
    assign o_m_axis_tdata = OUT_W'({w_entry_count, w_evicted_key, w_slot});

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps

module tb;

    localparam int ENT            = lct_pkg::DEF_ENTRIES;
    localparam int KIND_W         = lct_pkg::KIND_W;
    localparam int KEY_W          = lct_pkg::KEY_W;
    localparam int LEN_W          = lct_pkg::LEN_W;
    localparam int STATUS_W       = lct_pkg::STATUS_W;
    localparam int SLOT_W         = lct_pkg::SLOT_W;
    localparam int COUNT_W        = lct_pkg::COUNT_W;
    localparam int CFG_W          = lct_pkg::CFG_W;
    localparam int IN_DATA_W      = lct_pkg::IN_DATA_W;
    localparam int OUT_DATA_W     = lct_pkg::OUT_DATA_W;
    localparam int KEY_POOL_SIZE  = 20;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 12;

    // One request as the sender presents it.
    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [KEY_W-1:0]  key;
        logic [LEN_W-1:0]  start;
        logic [LEN_W-1:0]  nbytes;
        logic [LEN_W-1:0]  length;
    } t_cache_req;

    // One result as the block should report it.
    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
        logic [KEY_W-1:0]    ekey;
        logic [COUNT_W-1:0]  count;
        logic                last;
    } t_cache_resp;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    // chunk_key, start_byte, byte_count, chunk_length, zero fill
    logic [IN_DATA_W-1:0]  i_s_axis_tdata = '0;
    // kind
    logic [KIND_W-1:0]     i_s_axis_tuser = '0;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    // slot, evicted_key, entry_count, zero fill
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;
    // status
    logic [STATUS_W-1:0]   o_m_axis_tuser;
    logic                  o_m_axis_tlast;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_W-1:0]      i_cfg_wdata = '0;

    lru_chunk_tag_cache dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    always #2 i_clk = ~i_clk;

    t_cache_req  pending_reqs[$];
    t_cache_resp expected_resps[$];
    t_cache_req  req_on_bus;
    bit          req_taken = 1'b0;
    bit          idling_on = 1'b1;
    int unsigned send_gap = 0;
    int unsigned recv_stall = 0;
    int unsigned mismatch_count = 0;
    logic [KEY_W-1:0] key_pool [KEY_POOL_SIZE];

    // Directory model: tags, lengths, recency ranks (0 is most recent).
    logic             dir_valid [ENT];
    logic [KEY_W-1:0] dir_key   [ENT];
    logic [LEN_W-1:0] dir_len   [ENT];
    int unsigned      dir_rank  [ENT];
    int unsigned      dir_count;
    logic [CFG_W-1:0] dir_capacity;

    function automatic void push_result(input logic [STATUS_W-1:0] status, input int slot,
                                        input logic [KEY_W-1:0] ekey, input logic last);
        t_cache_resp r;
        r.status = status;
        r.slot   = SLOT_W'(slot);
        r.ekey   = ekey;
        r.count  = COUNT_W'(dir_count);
        r.last   = last;
        expected_resps.push_back(r);
    endfunction

    // Move an entry to most recent; entries that were more recent age by one.
    function automatic void make_most_recent(input int s);
        int unsigned old_rank;
        old_rank = dir_rank[s];
        for (int i = 0; i < ENT; i++) begin
            if (dir_valid[i] && dir_rank[i] < old_rank) begin
                dir_rank[i]++;
            end
        end
        dir_rank[s] = 0;
    endfunction

    // Apply one request to the directory model and queue its results.
    function automatic void predict_directory(input t_cache_req rq);
        int                 hit_slot;
        int                 victim;
        int                 free_slot;
        int unsigned        eff_cap;
        bit                 evicting;
        logic [LEN_W:0]     span;
        hit_slot = -1;
        if (rq.kind == lct_pkg::KIND_CLEAR) begin
            for (int i = 0; i < ENT; i++) begin
                dir_valid[i] = 1'b0;
                dir_rank[i]  = 0;
            end
            dir_count = 0;
            push_result(lct_pkg::STAT_MISS, 0, '0, 1'b1);
            return;
        end
        for (int i = 0; i < ENT; i++) begin
            if (hit_slot < 0 && dir_valid[i] && dir_key[i] == rq.key) begin
                hit_slot = i;
            end
        end

        // Lookup and bounded read check.
        if (rq.kind == lct_pkg::KIND_LOOKUP || rq.kind == lct_pkg::KIND_READ) begin
            span = {1'b0, rq.start} + {1'b0, rq.nbytes};
            if (hit_slot < 0) begin
                push_result(lct_pkg::STAT_MISS, 0, '0, 1'b1);
            end else if (rq.kind == lct_pkg::KIND_READ &&
                         span > {1'b0, dir_len[hit_slot]}) begin
                push_result(lct_pkg::STAT_OOR, hit_slot, '0, 1'b1);
            end else begin
                make_most_recent(hit_slot);
                push_result(lct_pkg::STAT_HIT, hit_slot, '0, 1'b1);
            end
            return;
        end

        // Update of a present key never evicts.
        if (hit_slot >= 0) begin
            dir_len[hit_slot] = rq.length;
            make_most_recent(hit_slot);
            push_result(lct_pkg::STAT_UPDATED, hit_slot, '0, 1'b1);
            return;
        end

        // New key: evict least recent entries until there is room.
        eff_cap = dir_capacity;
        if (eff_cap < 1) eff_cap = 1;
        if (eff_cap > ENT) eff_cap = ENT;
        evicting = 1'b1;
        while (evicting && dir_count >= eff_cap && dir_count > 0) begin
            victim = -1;
            for (int i = 0; i < ENT; i++) begin
                if (dir_valid[i] && dir_rank[i] == dir_count - 1) begin
                    victim = i;
                end
            end
            if (victim < 0) begin
                evicting = 1'b0;
            end else begin
                dir_valid[victim] = 1'b0;
                dir_rank[victim]  = 0;
                dir_count--;
                push_result(lct_pkg::STAT_EVICT, victim, dir_key[victim], 1'b0);
            end
        end

        // Store in the lowest free slot.
        free_slot = -1;
        for (int i = ENT - 1; i >= 0; i--) begin
            if (!dir_valid[i]) free_slot = i;
        end
        if (free_slot < 0) free_slot = 0;
        for (int i = 0; i < ENT; i++) begin
            if (dir_valid[i]) dir_rank[i]++;
        end
        dir_valid[free_slot] = 1'b1;
        dir_key[free_slot]   = rq.key;
        dir_len[free_slot]   = rq.length;
        dir_rank[free_slot]  = 0;
        dir_count++;
        push_result(lct_pkg::STAT_STORED, free_slot, '0, 1'b1);
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    function automatic t_cache_req random_request();
        t_cache_req  rq;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 2) begin
            rq.kind = lct_pkg::KIND_CLEAR;
        end else if (pick < 37) begin
            rq.kind = lct_pkg::KIND_INSERT;
        end else if (pick < 62) begin
            rq.kind = lct_pkg::KIND_LOOKUP;
        end else begin
            rq.kind = lct_pkg::KIND_READ;
        end
        if ($urandom_range(0, 9) == 0) begin
            rq.key = KEY_W'({$urandom, $urandom});
        end else begin
            rq.key = key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
        end
        // Mostly small offsets so that read checks both pass and fail.
        if ($urandom_range(0, 9) < 6) begin
            rq.start  = LEN_W'($urandom_range(0, 1000));
            rq.nbytes = LEN_W'($urandom_range(0, 1000));
        end else begin
            rq.start  = LEN_W'($urandom);
            rq.nbytes = LEN_W'($urandom);
        end
        rq.length = $urandom_range(0, 1) ? LEN_W'($urandom) : LEN_W'($urandom_range(0, 2000));
        return rq;
    endfunction

    task automatic queue_request(input logic [KIND_W-1:0] kind, input logic [KEY_W-1:0] key,
                                 input logic [LEN_W-1:0] start, input logic [LEN_W-1:0] nbytes,
                                 input logic [LEN_W-1:0] length);
        t_cache_req rq;
        rq.kind   = kind;
        rq.key    = key;
        rq.start  = start;
        rq.nbytes = nbytes;
        rq.length = length;
        pending_reqs.push_back(rq);
    endtask

    task automatic queue_random(input int n);
        for (int i = 0; i < n; i++) begin
            pending_reqs.push_back(random_request());
        end
    endtask

    // Wait until every request is taken and every result has come back.
    task automatic drain_all();
        while (pending_reqs.size() > 0 || i_s_axis_tvalid || expected_resps.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [CFG_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        dir_capacity = value;
    endtask

    // Request driver: presents queued requests, with random gaps after transfers.
    always @(negedge i_clk) begin
        if (req_taken || !i_s_axis_tvalid) begin
            if (req_taken && idling_on && $urandom_range(0, 5) == 0) begin
                send_gap = $urandom_range(1, 10);
            end
            if (send_gap > 0) begin
                send_gap--;
                i_s_axis_tvalid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                req_on_bus = pending_reqs.pop_front();
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tdata  <= {{(IN_DATA_W - KEY_W - 3 * LEN_W){1'b0}}, req_on_bus.length,
                                    req_on_bus.nbytes, req_on_bus.start, req_on_bus.key};
                i_s_axis_tuser  <= req_on_bus.kind;
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
        req_taken = 1'b0;
    end

    // Result receiver: ready with random stall bursts.
    always @(negedge i_clk) begin
        if (recv_stall > 0) begin
            recv_stall--;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
            if (idling_on && $urandom_range(0, 5) == 0) begin
                recv_stall = $urandom_range(1, 10);
            end
        end
    end

    // Monitor: predicts on each request transfer and checks each result transfer.
    always @(posedge i_clk) begin
        t_cache_resp want;
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            predict_directory(req_on_bus);
            req_taken = 1'b1;
        end
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (expected_resps.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual status %0h data %0h",
                         $time, o_m_axis_tuser, o_m_axis_tdata);
                mismatch_count++;
            end else begin
                want = expected_resps.pop_front();
                check_field("status", 64'(want.status), 64'(o_m_axis_tuser));
                check_field("slot", 64'(want.slot), 64'(o_m_axis_tdata[3:0]));
                check_field("evicted_key", 64'(want.ekey), 64'(o_m_axis_tdata[51:4]));
                check_field("entry_count", 64'(want.count), 64'(o_m_axis_tdata[56:52]));
                check_field("last", 64'(want.last), 64'(o_m_axis_tlast));
            end
        end
    end

    // Watchdog: ends the run when no transfer happens for too long.
    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("simulation failed");
        $finish;
    end

    // Stimulus sequence: directed checks, then random phases at several capacities.
    initial begin
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < KEY_POOL_SIZE; i++) begin
            key_pool[i] = KEY_W'({$urandom, $urandom});
        end
        for (int i = 0; i < ENT; i++) begin
            dir_valid[i] = 1'b0;
            dir_key[i]   = '0;
            dir_len[i]   = '0;
            dir_rank[i]  = 0;
        end
        dir_count    = 0;
        dir_capacity = lct_pkg::CAPACITY_RESET;

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Empty directory, field extremes, range check edges and an update.
        queue_request(lct_pkg::KIND_LOOKUP, '0, '0, '0, '0);
        queue_request(lct_pkg::KIND_READ, '1, '0, '0, '0);
        queue_request(lct_pkg::KIND_INSERT, '0, '1, '1, '0);
        queue_request(lct_pkg::KIND_INSERT, '1, '0, '0, '1);
        queue_request(lct_pkg::KIND_LOOKUP, '1, '0, '0, '0);
        queue_request(lct_pkg::KIND_READ, '0, '0, '0, '0);
        queue_request(lct_pkg::KIND_READ, '0, 25'd1, '0, '0);
        queue_request(lct_pkg::KIND_READ, '1, '1, '1, '0);
        queue_request(lct_pkg::KIND_READ, '1, '0, '1, '0);
        queue_request(lct_pkg::KIND_INSERT, '0, '0, '0, 25'd100);
        for (int i = 2; i < 6; i++) begin
            queue_request(lct_pkg::KIND_INSERT, key_pool[i], '0, '0, LEN_W'(i * 50));
        end
        drain_all();

        // Capacity zero acts as one: a new key flushes every older entry.
        write_capacity(5'd0);
        queue_request(lct_pkg::KIND_INSERT, 48'h1234_5678_9abc, '0, '0, 25'd10);
        queue_request(lct_pkg::KIND_INSERT, 48'h5a5a_a5a5_c3c3, '0, '0, 25'd20);
        queue_request(lct_pkg::KIND_INSERT, 48'h5a5a_a5a5_c3c3, '0, '0, 25'd30);
        queue_request(lct_pkg::KIND_LOOKUP, 48'h1234_5678_9abc, '0, '0, '0);
        queue_request(lct_pkg::KIND_CLEAR, 48'hffff_0000_ffff, '1, '1, '1);
        queue_request(lct_pkg::KIND_LOOKUP, 48'h5a5a_a5a5_c3c3, '0, '0, '0);
        drain_all();

        // Capacity above the entry count is clamped.
        write_capacity(5'd31);
        queue_random(60);
        drain_all();

        write_capacity(5'd16);
        queue_random(70);
        drain_all();

        // Shrinking to one forces a long eviction run on the next new key.
        write_capacity(5'd1);
        queue_random(40);
        drain_all();

        write_capacity(CFG_W'($urandom_range(2, 15)));
        queue_random(60);
        drain_all();

        // Last stretch at full rate on both sides.
        write_capacity(CFG_W'($urandom_range(2, 16)));
        idling_on = 1'b0;
        queue_random(80);
        drain_all();

        if (mismatch_count == 0 && expected_resps.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
